>>> hdl/hvst_pkg.sv
// Shared constants and types for the Hough vote smoothing and threshold block.
package hvst_pkg;

   // Sizing of the accumulator rows and the cell counts.
   localparam int MAX_ROW_CELLS = 1024;
   localparam int CELL_BITS     = 20;
   localparam int COL_BITS      = $clog2(MAX_ROW_CELLS);

   // Fixed widths of the register and result fields.
   localparam int WIDTH_BITS = 11;
   localparam int IDX_BITS   = 10;
   localparam int THR_BITS   = 24;

   // Column sums carry weights 1 2 1; the full sum carries weights up to 4.
   localparam int COLSUM_BITS = CELL_BITS + 2;
   localparam int SUM_BITS    = CELL_BITS + 4;
   localparam int CMP_BITS    = (SUM_BITS > THR_BITS) ? SUM_BITS : THR_BITS;

   // Output queue, a power of two deep.
   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   // Configuration register indexes.
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = THR_BITS;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROW_CELLS      = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_VOTE_THRESHOLD = CSR_IDX_BITS'(1);

   // One column of the 3x3 window: the cell two rows up, one row up, and the newest row.
   typedef struct packed {
      logic [CELL_BITS-1:0] top;
      logic [CELL_BITS-1:0] mid;
      logic [CELL_BITS-1:0] bot;
   } win_col_type;

   // One entry of the combined line store.
   typedef struct packed {
      logic [CELL_BITS-1:0] upper;
      logic [CELL_BITS-1:0] middle;
   } line_word_type;

   // One reported cell.
   typedef struct packed {
      logic [IDX_BITS-1:0] rho;
      logic [IDX_BITS-1:0] theta;
      logic [THR_BITS-1:0] sum;
   } result_type;

endpackage

>>> hdl/hvst_win_cell.sv
// One column cell of the 3x3 window chain, holding a column and its 1-2-1 sum.
module hvst_win_cell import hvst_pkg::*; (
   input  logic                   clock,
   input  logic                   shift,
   input  win_col_type            feed_col,
   output win_col_type            hold_col,
   output logic [COLSUM_BITS-1:0] hold_colsum
);

   win_col_type            col_ff;
   logic [COLSUM_BITS-1:0] colsum_ff;
   logic [COLSUM_BITS-1:0] colsum_in;

   // Vertical weights 1 2 1 of the column that moves in.
   always_comb begin
      colsum_in = COLSUM_BITS'(feed_col.top) + COLSUM_BITS'({feed_col.mid, 1'b0})
                + COLSUM_BITS'(feed_col.bot);
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         col_ff    <= feed_col;
         colsum_ff <= colsum_in;
      end
   end

   assign hold_col    = col_ff;
   assign hold_colsum = colsum_ff;

endmodule

>>> hdl/hvst_out_fifo.sv
// Small result queue that decouples the window pipeline from the result channel.
module hvst_out_fifo import hvst_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  result_type               push_data,
   input  logic                     pop,
   output logic                     out_valid,
   output result_type               out_data,
   output logic [FIFO_CNT_BITS-1:0] count
);

   result_type                 store_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0]   wr_ptr_ff;
   logic [FIFO_PTR_BITS-1:0]   rd_ptr_ff;
   logic [FIFO_CNT_BITS-1:0]   count_ff;
   logic [FIFO_CNT_BITS-1:0]   count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + FIFO_CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - FIFO_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_BITS'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = store_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

>>> hdl/hough_vote_smooth_threshold.sv
// Top level of the Hough accumulator 3x3 vote smoothing and threshold block.
//
//   channel  direction  handshake              word
//   req_     in         req_valid / req_stall  req_cell_count
//   rsp_     out        rsp_valid / rsp_stall  rsp_rho_col, rsp_theta_row, rsp_vote_sum
//   csr_     in         csr_valid / csr_ready  csr_index, csr_data
//
// One word is taken per clock cycle while req_stall is low. A result enters the queue after its
// cell word passed the line store read, then the window shift, then the sum and compare, and
// rsp_valid rises once the result sits in the queue, from which it can leave.
// The line store is a single port-pair memory read at the column of the new word and written
// in the next cycle, which sets the one-word-per-cycle pace.
// req_stall rises only when the result queue, together with the words still in flight,
// could fill; it does not look at rsp_stall combinationally.
// Reset is synchronous and clears the counters, the pipeline valids and the queue; the line
// stores are not cleared, so there is no clearing pass and words are taken right after reset.
module hough_vote_smooth_threshold import hvst_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // Cell words in raster order.
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [19:0]              req_cell_count,
   // Reported cells.
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [IDX_BITS-1:0]      rsp_rho_col,
   output logic [IDX_BITS-1:0]      rsp_theta_row,
   output logic [THR_BITS-1:0]      rsp_vote_sum,
   // Register writes.
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   localparam logic [CMP_BITS-1:0] SUM_SAT = CMP_BITS'({THR_BITS{1'b1}});

   // Configuration registers.
   logic [WIDTH_BITS-1:0] row_cells_ff;
   logic [THR_BITS-1:0]   vote_threshold_ff;

   // Raster position of the next word.
   logic [COL_BITS-1:0]   col_ff;
   logic [COL_BITS-1:0]   col_in;
   logic [IDX_BITS-1:0]   row_ff;
   logic [IDX_BITS-1:0]   row_in;
   logic [COL_BITS-1:0]   last_col;
   logic [COL_BITS-1:0]   cur_col;
   logic                  end_row;
   logic                  accept;

   // Stage one: the new word, its position and the line store read data.
   logic                  v1_ff;
   logic [CELL_BITS-1:0]  cell1_ff;
   logic [COL_BITS-1:0]   col1_ff;
   logic [IDX_BITS-1:0]   row1_ff;
   line_word_type         rd_ff;
   line_word_type         line_mem [MAX_ROW_CELLS];

   // Window chain: index 0 is the left column, 1 the centre, 2 the right, 3 the feed.
   win_col_type            chain [4];
   logic [COLSUM_BITS-1:0] colsum [3];

   // Stage two: the window holds the neighborhood of this centre cell.
   logic                  v2_ff;
   logic                  v2_in;
   logic [IDX_BITS-1:0]   rho2_ff;
   logic [IDX_BITS-1:0]   theta2_ff;
   logic [SUM_BITS-1:0]   total;
   logic [CMP_BITS-1:0]   total_cmp;
   logic                  hit;
   result_type            hit_word;

   // Result queue.
   logic                     pop;
   logic                     fifo_valid;
   result_type               fifo_word;
   logic [FIFO_CNT_BITS-1:0] fifo_count;
   logic [FIFO_CNT_BITS:0]   committed;

   // Register writes are always taken; software writes only while the block is idle, which the block does not enforce.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_cells_ff      <= WIDTH_BITS'(1024);
         vote_threshold_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROW_CELLS: begin
               row_cells_ff <= csr_data[WIDTH_BITS-1:0];
            end
            CSR_VOTE_THRESHOLD: begin
               vote_threshold_ff <= csr_data[THR_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Effective row width is clamped to the legal range; a counter already past the last
   // column of a narrowed row is pulled back so that the current word ends the row.
   always_comb begin
      if (row_cells_ff < WIDTH_BITS'(3)) begin
         last_col = COL_BITS'(2);
      end else if (32'(row_cells_ff) > MAX_ROW_CELLS) begin
         last_col = COL_BITS'(MAX_ROW_CELLS - 1);
      end else begin
         last_col = COL_BITS'(row_cells_ff - WIDTH_BITS'(1));
      end
      cur_col = (col_ff > last_col) ? last_col : col_ff;
      end_row = (cur_col == last_col);
      col_in  = end_row ? '0 : cur_col + COL_BITS'(1);
      row_in  = end_row ? row_ff + IDX_BITS'(1) : row_ff;
   end

   // Credit check: every word in flight and every queued result holds a queue slot.
   assign committed = (FIFO_CNT_BITS + 1)'(fifo_count) + (FIFO_CNT_BITS + 1)'(v1_ff)
                    + (FIFO_CNT_BITS + 1)'(v2_ff);
   assign req_stall = (committed >= (FIFO_CNT_BITS + 1)'(FIFO_DEPTH));
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         v1_ff  <= 1'b0;
      end else begin
         v1_ff <= accept;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cell1_ff <= CELL_BITS'(req_cell_count);
         col1_ff  <= cur_col;
         row1_ff  <= row_ff;
      end
   end

   // Line store: read at the new word's column, written in the next cycle with the middle
   // row moving up and the new word becoming the middle row. The same column is not read
   // again before that write, since a row is at least three words long.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= line_mem[cur_col];
      end
      if (v1_ff) begin
         line_mem[col1_ff] <= '{upper: rd_ff.middle, middle: cell1_ff};
      end
   end

   assign chain[3] = '{top: rd_ff.upper, mid: rd_ff.middle, bot: cell1_ff};

   for (genvar k = 0; k < 3; k++) begin : g_win
      hvst_win_cell u_cell (
         .clock       (clock),
         .shift       (v1_ff),
         .feed_col    (chain[k+1]),
         .hold_col    (chain[k]),
         .hold_colsum (colsum[k])
      );
   end

   // Only centres below the top padding row and right of the left padding column qualify.
   assign v2_in = v1_ff && (row1_ff >= IDX_BITS'(2)) && (col1_ff >= COL_BITS'(2));

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (v1_ff) begin
         rho2_ff   <= IDX_BITS'(col1_ff) - IDX_BITS'(1);
         theta2_ff <= row1_ff - IDX_BITS'(1);
      end
   end

   // Horizontal weights 1 2 1 over the column sums give the full 3x3 kernel.
   always_comb begin
      total     = SUM_BITS'(colsum[0]) + SUM_BITS'({colsum[1], 1'b0}) + SUM_BITS'(colsum[2]);
      total_cmp = CMP_BITS'(total);
      hit       = v2_ff && (chain[1].mid != '0)
               && (total_cmp >= CMP_BITS'(vote_threshold_ff));
      hit_word.rho   = rho2_ff;
      hit_word.theta = theta2_ff;
      hit_word.sum   = (total_cmp > SUM_SAT) ? {THR_BITS{1'b1}} : THR_BITS'(total_cmp);
   end

   assign pop = fifo_valid && !rsp_stall;

   hvst_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (hit),
      .push_data (hit_word),
      .pop       (pop),
      .out_valid (fifo_valid),
      .out_data  (fifo_word),
      .count     (fifo_count)
   );

   assign rsp_valid     = fifo_valid;
   assign rsp_rho_col   = fifo_word.rho;
   assign rsp_theta_row = fifo_word.theta;
   assign rsp_vote_sum  = fifo_word.sum;

`ifndef ASSERT_OFF
   // The credit check must keep the queue from overflowing.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      hit |-> (fifo_count != FIFO_CNT_BITS'(FIFO_DEPTH)))
      else $error("result queue written while full");

   // The queue fill follows the pushes and pops of the previous cycle.
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (fifo_count == $past(fifo_count) + FIFO_CNT_BITS'($past(hit))
                                      - FIFO_CNT_BITS'($past(pop))))
      else $error("result queue fill count out of step");

   // A centre cell is only evaluated after its word went through the line store stage.
   a_stage_order: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> $past(v1_ff))
      else $error("window stage valid without a preceding word");
`endif

endmodule
